@@ sv/les_pkg.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler package
// Shared sizes, codes and the structs passed along the floor cell chain.
// ----------------------------------------------------------------------------
package les_pkg;

    // Number of floors served by the car
    localparam int NUM_FLOORS = 32;
    // Width of a floor number inside the block
    localparam int FLOOR_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    // Width of the floor fields on the channels
    localparam int CALL_W = 5;
    // Counter of set call bits over all three maps
    localparam int CNT_W = $clog2(3 * NUM_FLOORS + 1);

    typedef logic [FLOOR_W-1:0] floor_t;
    typedef logic [CNT_W-1:0]   count_t;

    typedef enum logic [1:0] {
        FN_UP_CALL    = 2'd0,
        FN_DOWN_CALL  = 2'd1,
        FN_CABIN_CALL = 2'd2,
        FN_SERVE      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DIR_UP   = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_IDLE = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } ctl_state_t;

    // Bit positions of the per-floor call bits
    localparam int BIT_UP    = 0;
    localparam int BIT_DOWN  = 1;
    localparam int BIT_CABIN = 2;

    // Command broadcast from the controller to every floor cell
    typedef struct packed {
        logic   set_en;
        func_t  set_kind;
        logic   clr_en;
        floor_t floor;
    } cell_cmd_t;

    // Search record that travels up the cell chain, one floor per cycle
    typedef struct packed {
        logic   wave;
        logic   up_found;
        floor_t up_lo;
        logic   dn_found;
        floor_t dn_hi;
        logic   cab_found;
        floor_t cab_lo;
        logic   su_found;
        floor_t su_floor;
        logic   sd_found;
        floor_t sd_floor;
    } sweep_t;

endpackage

@@ sv/les_item_if.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler input channel
// Valid/ready channel that carries one call or serve transaction.
// ----------------------------------------------------------------------------
interface les_item_if;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [les_pkg::CALL_W-1:0] call_floor;

    modport source (output valid, output func, output call_floor, input ready);
    modport sink   (input valid, input func, input call_floor, output ready);

endinterface

@@ sv/les_result_if.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler result channel
// Valid/ready channel that carries one result transaction per input.
// ----------------------------------------------------------------------------
interface les_result_if;

    logic                       valid;
    logic                       ready;
    logic [les_pkg::CALL_W-1:0] stop_floor;
    logic                       stop_valid;
    logic [1:0]                 new_direction;
    logic                       calls_pending;

    modport source (
        output valid, output stop_floor, output stop_valid,
        output new_direction, output calls_pending, input ready
    );
    modport sink (
        input valid, input stop_floor, input stop_valid,
        input new_direction, input calls_pending, output ready
    );

endinterface

@@ sv/les_cell.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator floor cell
// Holds the up, down and cabin call bits of one floor and folds this floor
// into the search record that passes through on its way up the chain.
// ----------------------------------------------------------------------------
module les_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  les_pkg::floor_t    idx,
    input  les_pkg::cell_cmd_t cmd,
    input  les_pkg::floor_t    cur_floor,
    input  les_pkg::sweep_t    rec_in,
    output les_pkg::sweep_t    rec_out,
    output logic [2:0]         bits
);

    logic            up_reg;
    logic            up_next;
    logic            dn_reg;
    logic            dn_next;
    logic            cab_reg;
    logic            cab_next;
    logic            wave_reg;
    les_pkg::sweep_t rec_reg;
    les_pkg::sweep_t rec_next;
    logic            hit;

    assign hit = (cmd.floor == idx);

    // Set or clear this floor's call bits
    always_comb
    begin
        up_next  = up_reg;
        dn_next  = dn_reg;
        cab_next = cab_reg;
        if (cmd.set_en && hit)
        begin
            case (cmd.set_kind)
                les_pkg::FN_UP_CALL:    up_next  = 1'b1;
                les_pkg::FN_DOWN_CALL:  dn_next  = 1'b1;
                les_pkg::FN_CABIN_CALL: cab_next = 1'b1;
                default:                ;
            endcase
        end
        if (cmd.clr_en && hit)
        begin
            up_next  = 1'b0;
            dn_next  = 1'b0;
            cab_next = 1'b0;
        end
    end

    // Fold this floor into the passing search record
    always_comb
    begin
        rec_next = rec_in;
        if (!rec_in.up_found && up_reg)
        begin
            rec_next.up_found = 1'b1;
            rec_next.up_lo    = idx;
        end
        if (dn_reg)
        begin
            rec_next.dn_found = 1'b1;
            rec_next.dn_hi    = idx;
        end
        if (!rec_in.cab_found && cab_reg)
        begin
            rec_next.cab_found = 1'b1;
            rec_next.cab_lo    = idx;
        end
        if (!rec_in.su_found && (up_reg || cab_reg) && (idx >= cur_floor))
        begin
            rec_next.su_found = 1'b1;
            rec_next.su_floor = idx;
        end
        if ((dn_reg || cab_reg) && (idx < cur_floor))
        begin
            rec_next.sd_found = 1'b1;
            rec_next.sd_floor = idx;
        end
    end

    // Call bits and wave marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= 1'b0;
            dn_reg   <= 1'b0;
            cab_reg  <= 1'b0;
            wave_reg <= 1'b0;
        end
        else
        begin
            up_reg   <= up_next;
            dn_reg   <= dn_next;
            cab_reg  <= cab_next;
            wave_reg <= rec_in.wave;
        end
    end

    // Search record payload
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_comb
    begin
        rec_out      = rec_reg;
        rec_out.wave = wave_reg;
    end

    assign bits = {cab_reg, dn_reg, up_reg};

endmodule

@@ sv/les_ctrl.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler controller
// Takes transactions, drives the cell chain, applies the LOOK rule to the
// search record at the chain's end and holds the result register.
// ----------------------------------------------------------------------------
module les_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    les_item_if.sink           item,
    les_result_if.source       result,
    output les_pkg::cell_cmd_t cmd,
    output les_pkg::sweep_t    inject,
    output les_pkg::floor_t    cur_floor,
    input  les_pkg::sweep_t    last,
    input  logic [2:0]         cell_bits [les_pkg::NUM_FLOORS]
);

    les_pkg::ctl_state_t          state_reg;
    les_pkg::ctl_state_t          state_next;
    les_pkg::floor_t              cur_reg;
    les_pkg::floor_t              cur_next;
    les_pkg::dir_t                dir_reg;
    les_pkg::dir_t                dir_next;
    les_pkg::count_t              cnt_reg;
    les_pkg::count_t              cnt_next;
    les_pkg::floor_t              pend_stop_reg;
    les_pkg::floor_t              pend_stop_next;
    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    les_pkg::dir_t                pend_dir_reg;
    les_pkg::dir_t                pend_dir_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [les_pkg::CALL_W-1:0]   stop_reg;
    logic [les_pkg::CALL_W-1:0]   stop_next;
    logic                         sval_reg;
    logic                         sval_next;
    les_pkg::dir_t                odir_reg;
    les_pkg::dir_t                odir_next;
    logic                         pend_calls_reg;
    logic                         pend_calls_next;

    les_pkg::func_t  func;
    les_pkg::floor_t call_idx;
    logic            call_ok;
    logic            already;
    logic            item_fire;
    logic            out_free;
    logic [2:0]      call_bits;
    logic [2:0]      stop_bits;
    les_pkg::count_t pop;
    les_pkg::count_t cnt_after;
    les_pkg::dir_t   dec_dir;
    logic            dec_found;
    les_pkg::floor_t dec_stop;

    assign func      = les_pkg::func_t'(item.func);
    assign call_idx  = les_pkg::floor_t'(item.call_floor);
    assign call_ok   = (32'(item.call_floor) < 32'(les_pkg::NUM_FLOORS));
    assign out_free  = !out_vld_reg || result.ready;
    assign item.ready = (state_reg == les_pkg::ST_IDLE) && out_free;
    assign item_fire = item.valid && item.ready;
    assign cur_floor = cur_reg;

    // Look up the bit that a call would set
    assign call_bits = cell_bits[call_idx];
    always_comb
    begin
        case (func)
            les_pkg::FN_UP_CALL:    already = call_bits[les_pkg::BIT_UP];
            les_pkg::FN_DOWN_CALL:  already = call_bits[les_pkg::BIT_DOWN];
            les_pkg::FN_CABIN_CALL: already = call_bits[les_pkg::BIT_CABIN];
            default:                already = 1'b1;
        endcase
    end

    // Count the bits cleared at the chosen stop
    assign stop_bits = cell_bits[pend_stop_reg];
    assign pop = les_pkg::count_t'(stop_bits[les_pkg::BIT_UP])
               + les_pkg::count_t'(stop_bits[les_pkg::BIT_DOWN])
               + les_pkg::count_t'(stop_bits[les_pkg::BIT_CABIN]);
    assign cnt_after = pend_valid_reg ? (cnt_reg - pop) : cnt_reg;

    // Apply the LOOK rule to the finished search record
    always_comb
    begin
        dec_dir   = dir_reg;
        dec_found = 1'b0;
        dec_stop  = last.su_floor;
        if (dir_reg != les_pkg::DIR_UP && dir_reg != les_pkg::DIR_DOWN)
        begin
            if (last.up_found)
                dec_dir = les_pkg::DIR_UP;
            else if (last.dn_found)
                dec_dir = les_pkg::DIR_DOWN;
            else if (last.cab_lo > cur_reg)
                dec_dir = les_pkg::DIR_UP;
            else
                dec_dir = les_pkg::DIR_DOWN;
        end
        if (dec_dir == les_pkg::DIR_UP)
        begin
            if (last.su_found)
            begin
                dec_found = 1'b1;
                dec_stop  = last.su_floor;
            end
            else if (last.sd_found)
            begin
                dec_found = 1'b1;
                dec_stop  = last.sd_floor;
                dec_dir   = les_pkg::DIR_DOWN;
            end
        end
        else
        begin
            if (last.sd_found)
            begin
                dec_found = 1'b1;
                dec_stop  = last.sd_floor;
            end
            else if (last.su_found)
            begin
                dec_found = 1'b1;
                dec_stop  = last.su_floor;
                dec_dir   = les_pkg::DIR_UP;
            end
        end
        // Neither sweep found a stop: fall back to the hall calls
        if (!dec_found)
        begin
            if (last.up_found)
            begin
                dec_found = 1'b1;
                dec_stop  = last.up_lo;
                dec_dir   = les_pkg::DIR_UP;
            end
            else
            begin
                dec_found = last.dn_found;
                dec_stop  = last.dn_hi;
                dec_dir   = les_pkg::DIR_DOWN;
            end
        end
    end

    // Launch a search wave for a serve transaction with calls pending
    always_comb
    begin
        inject      = '0;
        inject.wave = item_fire && (func == les_pkg::FN_SERVE) && (cnt_reg != '0);
    end

    // Next state, cell commands and result register
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        dir_next        = dir_reg;
        cnt_next        = cnt_reg;
        pend_stop_next  = pend_stop_reg;
        pend_valid_next = pend_valid_reg;
        pend_dir_next   = pend_dir_reg;
        out_vld_next    = out_vld_reg && !result.ready;
        stop_next       = stop_reg;
        sval_next       = sval_reg;
        odir_next       = odir_reg;
        pend_calls_next = pend_calls_reg;

        cmd.set_en   = 1'b0;
        cmd.set_kind = func;
        cmd.clr_en   = 1'b0;
        cmd.floor    = call_idx;

        case (state_reg)
            les_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (func != les_pkg::FN_SERVE)
                    begin
                        cmd.set_en = call_ok;
                        if (call_ok && !already)
                            cnt_next = cnt_reg + les_pkg::count_t'(1);
                        out_vld_next    = 1'b1;
                        stop_next       = les_pkg::CALL_W'(cur_reg);
                        sval_next       = 1'b0;
                        odir_next       = dir_reg;
                        pend_calls_next = (cnt_next != '0);
                    end
                    else if (cnt_reg == '0)
                    begin
                        dir_next        = les_pkg::DIR_IDLE;
                        out_vld_next    = 1'b1;
                        stop_next       = les_pkg::CALL_W'(cur_reg);
                        sval_next       = 1'b0;
                        odir_next       = les_pkg::DIR_IDLE;
                        pend_calls_next = 1'b0;
                    end
                    else
                    begin
                        state_next = les_pkg::ST_SCAN;
                    end
                end
            end
            les_pkg::ST_SCAN:
            begin
                // Hold the decision once the wave leaves the top floor
                if (last.wave)
                begin
                    pend_stop_next  = dec_stop;
                    pend_valid_next = dec_found;
                    pend_dir_next   = dec_dir;
                    state_next      = les_pkg::ST_WRITE;
                end
            end
            les_pkg::ST_WRITE:
            begin
                cmd.floor = pend_stop_reg;
                if (out_free)
                begin
                    cmd.clr_en = pend_valid_reg;
                    cnt_next   = cnt_after;
                    if (pend_valid_reg)
                        cur_next = pend_stop_reg;
                    dir_next = (cnt_after != '0) ? pend_dir_reg : les_pkg::DIR_IDLE;
                    out_vld_next    = 1'b1;
                    stop_next       = les_pkg::CALL_W'(cur_next);
                    sval_next       = pend_valid_reg;
                    odir_next       = dir_next;
                    pend_calls_next = (cnt_after != '0);
                    state_next      = les_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = les_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= les_pkg::ST_IDLE;
            cur_reg     <= '0;
            dir_reg     <= les_pkg::DIR_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            dir_reg     <= dir_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Decision and result payload
    always_ff @(posedge clk)
    begin
        pend_stop_reg  <= pend_stop_next;
        pend_valid_reg <= pend_valid_next;
        pend_dir_reg   <= pend_dir_next;
        stop_reg       <= stop_next;
        sval_reg       <= sval_next;
        odir_reg       <= odir_next;
        pend_calls_reg <= pend_calls_next;
    end

    assign result.valid         = out_vld_reg;
    assign result.stop_floor    = stop_reg;
    assign result.stop_valid    = sval_reg;
    assign result.new_direction = 2'(odir_reg);
    assign result.calls_pending = pend_calls_reg;

endmodule

@@ sv/look_elevator_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler core
// One car: per-floor call bits in a chain of floor cells, and a controller
// that picks the next stop by the LOOK rule.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+----------
//  item     | in  | func, call_floor                                 | valid/ready
//  result   | out | stop_floor, stop_valid, new_direction,           | valid/ready
//           |     | calls_pending                                    |
//
// Call items and serve items with no call pending have their result registered
// on acceptance. A serve item with calls pending sends a search wave through
// the floor cells, one floor per cycle; ST_SCAN and ST_WRITE then register
// its result, and the next item is taken once that result is registered.
// Reset clears every call bit, puts the car at floor 0 and makes it idle.
// A stalled result holds in the output register; input waits until it leaves.
// ----------------------------------------------------------------------------
module look_elevator_scheduler_core
(
    input  logic         clk,
    input  logic         rst_n,
    les_item_if.sink     item,
    les_result_if.source result
);

    les_pkg::cell_cmd_t cmd;
    les_pkg::sweep_t    inject;
    les_pkg::floor_t    cur_floor;
    les_pkg::sweep_t    chain_in  [les_pkg::NUM_FLOORS];
    les_pkg::sweep_t    chain_out [les_pkg::NUM_FLOORS];
    logic [2:0]         cell_bits [les_pkg::NUM_FLOORS];

    les_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .inject    (inject),
        .cur_floor (cur_floor),
        .last      (chain_out[les_pkg::NUM_FLOORS-1]),
        .cell_bits (cell_bits)
    );

    // Chain the floor cells, lowest floor first
    for (genvar i = 0; i < les_pkg::NUM_FLOORS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign chain_in[i] = inject;
        end
        else
        begin : g_link
            assign chain_in[i] = chain_out[i-1];
        end

        les_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (les_pkg::floor_t'(i)),
            .cmd       (cmd),
            .cur_floor (cur_floor),
            .rec_in    (chain_in[i]),
            .rec_out   (chain_out[i]),
            .bits      (cell_bits[i])
        );
    end

endmodule

@@ sv/les_checker.sv @@
// ----------------------------------------------------------------------------
// LOOK elevator scheduler port checker
// Watches the channel ports of the core and flags illegal result sequences.
// ----------------------------------------------------------------------------
module les_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [les_pkg::CALL_W-1:0] stop_floor,
    input logic                       stop_valid,
    input logic [1:0]                 new_direction,
    input logic                       calls_pending
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(stop_floor)
            && $stable(stop_valid) && $stable(new_direction) && $stable(calls_pending))
    else $error("result changed while stalled");

    // Block new input while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !item_ready)
    else $error("input taken while result stalled");

    // No call left means the car is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !calls_pending |-> new_direction == 2'(les_pkg::DIR_IDLE))
    else $error("direction set with no call pending");

    // A served stop with calls left keeps a travel direction
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && stop_valid && calls_pending
            |-> new_direction == 2'(les_pkg::DIR_UP)
             || new_direction == 2'(les_pkg::DIR_DOWN))
    else $error("idle after a stop with calls left");

endmodule

bind look_elevator_scheduler_core les_checker u_les_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .item_ready    (item.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .stop_floor    (result.stop_floor),
    .stop_valid    (result.stop_valid),
    .new_direction (result.new_direction),
    .calls_pending (result.calls_pending)
);
